// ----- rtl/dfs_pkg.sv -----
package dfs_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int FRACTION_BITS = 16;
    localparam int LINE_WEIGHTS  = 6;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int KIND_W = 3;
    localparam int CUM_W  = 24;
    localparam int WGT_W  = 16;
    localparam int EN_W   = 16;
    localparam int RND_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SPAN_W = 30;
    localparam int POS_W  = 32;

    // Largest usable fraction; a narrower fraction saturates the random input.
    localparam logic [RND_W-1:0] FRAC_MAX = (FRACTION_BITS >= RND_W) ? '1 :
        RND_W'((1 << FRACTION_BITS) - 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Z   = 3'd5;

    localparam logic signed [5:0] CODE_E_NU      = 6'sd12;
    localparam logic signed [5:0] CODE_MU_NU     = 6'sd14;
    localparam logic signed [5:0] CODE_TAU_NU    = 6'sd16;
    localparam logic signed [5:0] CODE_E_ANTINU  = -6'sd12;
    localparam logic signed [5:0] CODE_MU_ANTINU = -6'sd14;
    localparam logic signed [5:0] CODE_TAU_ANTINU = -6'sd16;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [EN_W-1:0]   energy;
        logic [CUM_W-1:0]  cumulative;
    } entry_t;

    typedef struct packed {
        logic [1:0]                          command;
        logic [EN_W-1:0]                     energy;
        logic [LINE_WEIGHTS-1:0][WGT_W-1:0]  weights;
        logic [RND_W-1:0]                    random_value;
    } item_t;

    typedef struct packed {
        logic              found;
        logic [KIND_W-1:0] kind;
        logic [EN_W-1:0]   energy;
        logic [CNT_W-1:0]  count;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        entry_t            entry;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
    } ram_rd_t;

    typedef struct packed {
        logic signed [POS_W-1:0] centre_x;
        logic signed [POS_W-1:0] centre_y;
        logic signed [POS_W-1:0] centre_z;
        logic [SPAN_W-1:0]       span_x;
        logic [SPAN_W-1:0]       span_y;
        logic [SPAN_W-1:0]       span_z;
    } geom_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos_t;

    // Kind index follows the order of the weights on a flux line.
    function automatic logic signed [5:0] kind_code(input logic [KIND_W-1:0] kind);
        logic signed [5:0] code;
        unique case (kind)
            3'd1:    code = CODE_MU_NU;
            3'd2:    code = CODE_TAU_NU;
            3'd3:    code = CODE_E_ANTINU;
            3'd4:    code = CODE_MU_ANTINU;
            3'd5:    code = CODE_TAU_ANTINU;
            default: code = CODE_E_NU;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/dfs_if.sv -----
interface dfs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] energy;
    logic [15:0] weight_e_nu;
    logic [15:0] weight_mu_nu;
    logic [15:0] weight_tau_nu;
    logic [15:0] weight_e_antinu;
    logic [15:0] weight_mu_antinu;
    logic [15:0] weight_tau_antinu;
    logic [15:0] random_value;

    modport source (
        output valid, command, energy, weight_e_nu, weight_mu_nu, weight_tau_nu,
               weight_e_antinu, weight_mu_antinu, weight_tau_antinu, random_value,
        input  ready
    );
    modport sink (
        input  valid, command, energy, weight_e_nu, weight_mu_nu, weight_tau_nu,
               weight_e_antinu, weight_mu_antinu, weight_tau_antinu, random_value,
        output ready
    );
endinterface

interface dfs_result_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [5:0]  particle_code;
    logic [15:0]        sampled_energy;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [8:0]         entry_count;
    logic               overflow;

    modport source (
        output valid, found, particle_code, sampled_energy, pos_x, pos_y, pos_z,
               entry_count, overflow,
        input  ready
    );
    modport sink (
        input  valid, found, particle_code, sampled_energy, pos_x, pos_y, pos_z,
               entry_count, overflow,
        output ready
    );
endinterface

interface dfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/dfs_table_ram.sv -----
module dfs_table_ram (
    input  logic              clk,
    input  dfs_pkg::ram_wr_t  wr,
    input  dfs_pkg::ram_rd_t  rd,
    output dfs_pkg::entry_t   rd_data
);

    dfs_pkg::entry_t mem_array [dfs_pkg::TABLE_DEPTH];
    dfs_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_array[wr.addr] <= wr.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem_array[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/dfs_position.sv -----
module dfs_position (
    input  logic                       clk,
    input  dfs_pkg::geom_t             geom,
    input  logic [dfs_pkg::RND_W-1:0]  frac,
    output dfs_pkg::pos_t              pos
);

    localparam int PROD_W = dfs_pkg::SPAN_W + dfs_pkg::RND_W;

    logic [PROD_W-1:0] prod_x_reg;
    logic [PROD_W-1:0] prod_y_reg;
    logic [dfs_pkg::POS_W-1:0] part_x;
    logic [dfs_pkg::POS_W-1:0] part_y;
    logic [dfs_pkg::POS_W-1:0] half_x;
    logic [dfs_pkg::POS_W-1:0] half_y;
    logic [dfs_pkg::POS_W-1:0] half_z;

    // The fraction is held steady for the whole item, so the products settle
    // in the cycle after the item is taken, before the result is formed.
    always_ff @(posedge clk)
    begin
        prod_x_reg <= PROD_W'(geom.span_x) * PROD_W'(frac);
        prod_y_reg <= PROD_W'(geom.span_y) * PROD_W'(frac);
    end

    assign part_x = dfs_pkg::POS_W'(prod_x_reg >> dfs_pkg::FRACTION_BITS);
    assign part_y = dfs_pkg::POS_W'(prod_y_reg >> dfs_pkg::FRACTION_BITS);
    assign half_x = dfs_pkg::POS_W'(geom.span_x >> 1);
    assign half_y = dfs_pkg::POS_W'(geom.span_y >> 1);
    assign half_z = dfs_pkg::POS_W'(geom.span_z >> 1);

    assign pos.x = $signed(dfs_pkg::POS_W'($unsigned(geom.centre_x) + part_x - half_x));
    assign pos.y = $signed(dfs_pkg::POS_W'($unsigned(geom.centre_y) + part_y - half_y));
    assign pos.z = $signed(dfs_pkg::POS_W'($unsigned(geom.centre_z) - half_z));

endmodule

// ----- rtl/dfs_sequencer.sv -----
module dfs_sequencer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  dfs_pkg::item_t             item,
    output logic                       item_ready,
    input  logic                       slot_free,
    output logic                       push,
    output dfs_pkg::result_t           result,
    output logic [dfs_pkg::RND_W-1:0]  frac,
    output dfs_pkg::ram_wr_t           ram_wr,
    output dfs_pkg::ram_rd_t           ram_rd,
    input  dfs_pkg::entry_t            ram_rd_data
);

    localparam int PROD_W = dfs_pkg::RND_W + dfs_pkg::CUM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [dfs_pkg::CNT_W-1:0]   fill_reg;
    logic [dfs_pkg::CUM_W-1:0]   total_reg;
    logic [dfs_pkg::CUM_W-1:0]   total_next;
    logic [dfs_pkg::CUM_W:0]     total_sum;
    logic [dfs_pkg::KIND_W-1:0]  k_reg;
    logic [dfs_pkg::CNT_W-1:0]   scan_reg;
    logic [dfs_pkg::CNT_W-1:0]   scan_next;
    logic [PROD_W-1:0]           prod_reg;
    logic [dfs_pkg::CUM_W-1:0]   scaled;
    logic [dfs_pkg::LINE_WEIGHTS-1:0][dfs_pkg::WGT_W-1:0] weight_reg;
    logic [dfs_pkg::EN_W-1:0]    load_energy_reg;
    logic [dfs_pkg::RND_W-1:0]   frac_reg;
    logic [dfs_pkg::RND_W-1:0]   frac_in;
    logic [dfs_pkg::WGT_W-1:0]   w_cur;
    logic                        table_full;
    logic                        scan_hit;
    logic                        scan_last;
    logic                        found_reg;
    logic                        ovf_reg;
    logic [dfs_pkg::KIND_W-1:0]  kind_reg;
    logic [dfs_pkg::EN_W-1:0]    energy_reg;
    logic                        accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign push       = (state_reg == S_DONE) && slot_free;

    assign frac_in = (item.random_value > dfs_pkg::FRAC_MAX) ? dfs_pkg::FRAC_MAX
                                                             : item.random_value;
    assign frac    = frac_reg;

    assign w_cur      = weight_reg[k_reg];
    assign table_full = (fill_reg == dfs_pkg::CNT_W'(dfs_pkg::TABLE_DEPTH));
    assign total_sum  = {1'b0, total_reg} + (dfs_pkg::CUM_W + 1)'(w_cur);
    assign total_next = total_sum[dfs_pkg::CUM_W] ? '1 : total_sum[dfs_pkg::CUM_W-1:0];

    assign scaled    = dfs_pkg::CUM_W'(prod_reg >> dfs_pkg::FRACTION_BITS);
    assign scan_hit  = scaled < ram_rd_data.cumulative;
    assign scan_next = scan_reg + 1'b1;
    assign scan_last = (scan_next == fill_reg);

    always_comb
    begin
        ram_wr.en               = (state_reg == S_LOAD) && (w_cur != '0) && !table_full;
        ram_wr.addr             = fill_reg[dfs_pkg::IDX_W-1:0];
        ram_wr.entry.kind       = k_reg;
        ram_wr.entry.energy     = load_energy_reg;
        ram_wr.entry.cumulative = total_next;
    end

    // The read for the next entry goes out while the current one is compared.
    always_comb
    begin
        ram_rd.en   = ((state_reg == S_MUL) && (fill_reg != '0)) ||
                      ((state_reg == S_SCAN) && !scan_hit && !scan_last);
        ram_rd.addr = (state_reg == S_MUL) ? '0 : scan_next[dfs_pkg::IDX_W-1:0];
    end

    always_comb
    begin
        result.found    = found_reg;
        result.kind     = kind_reg;
        result.energy   = energy_reg;
        result.count    = fill_reg;
        result.overflow = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            total_reg       <= '0;
            k_reg           <= '0;
            scan_reg        <= '0;
            found_reg       <= 1'b0;
            ovf_reg         <= 1'b0;
            kind_reg        <= '0;
            energy_reg      <= '0;
            prod_reg        <= '0;
            weight_reg      <= '0;
            load_energy_reg <= '0;
            frac_reg        <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        found_reg       <= 1'b0;
                        ovf_reg         <= 1'b0;
                        k_reg           <= '0;
                        weight_reg      <= item.weights;
                        load_energy_reg <= item.energy;
                        frac_reg        <= frac_in;
                        prod_reg        <= PROD_W'(frac_in) * PROD_W'(total_reg);
                        unique case (dfs_pkg::cmd_t'(item.command))
                            dfs_pkg::CMD_CLEAR:
                            begin
                                fill_reg  <= '0;
                                total_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            dfs_pkg::CMD_LOAD:   state_reg <= S_LOAD;
                            dfs_pkg::CMD_SAMPLE: state_reg <= S_MUL;
                            dfs_pkg::CMD_NONE:   state_reg <= S_DONE;
                            default:             state_reg <= S_DONE;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    if (w_cur != '0)
                    begin
                        if (table_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            total_reg <= total_next;
                            fill_reg  <= fill_reg + 1'b1;
                        end
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == dfs_pkg::KIND_W'(dfs_pkg::LINE_WEIGHTS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_MUL:
                begin
                    scan_reg  <= '0;
                    state_reg <= (fill_reg == '0) ? S_DONE : S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        found_reg  <= 1'b1;
                        kind_reg   <= ram_rd_data.kind;
                        energy_reg <= ram_rd_data.energy;
                        state_reg  <= S_DONE;
                    end
                    else if (scan_last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        scan_reg <= scan_next;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= dfs_pkg::CNT_W'(dfs_pkg::TABLE_DEPTH))
        else $error("table fill count exceeds depth");

    a_fill_steps: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fill_reg == $past(fill_reg) || fill_reg == $past(fill_reg) + 1'b1 ||
                  fill_reg == '0))
        else $error("table fill count moved by more than one entry");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr.en |-> (fill_reg < dfs_pkg::CNT_W'(dfs_pkg::TABLE_DEPTH)))
        else $error("table write beyond the filled region's limit");

    a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg < fill_reg))
        else $error("scan compared an entry that was never written");

    a_push_returns: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (state_reg == S_IDLE) && !found_reg == !$past(found_reg))
        else $error("result transfer did not return the sequencer to idle");

endmodule

// ----- rtl/discrete_flux_sampler_core.sv -----
// Discrete flux sampler. Load items visit the six weight slots of a line one per
// cycle and append a table entry for each nonzero weight, or flag overflow when the
// table is full; the next item is taken only after the last slot. A sample item
// scales its fraction by the total flux and scans the table in a simple dual-port
// synchronous memory, one entry per cycle with the next read issued while the
// current entry is compared; it stops at the first entry whose cumulative flux
// exceeds the scaled fraction or at the last entry, and skips an empty table. Clear
// items empty the table and, like the unused command, go straight to the result.
// Every result is registered in the cycle before the block can take the next item.
// The result register lets the next item be taken while a result still waits at the
// output; the block stalls only when a second result waits behind it. Configuration
// writes are taken at any time and should only be made while the block is idle.
module discrete_flux_sampler_core (
    input  logic         clk,
    input  logic         rst_n,
    dfs_item_if.sink     flux_item,
    dfs_result_if.source flux_result,
    dfs_cfg_if.sink      cfg_wr
);

    dfs_pkg::geom_t   geom_reg;
    dfs_pkg::item_t   item;
    dfs_pkg::result_t result;
    dfs_pkg::ram_wr_t ram_wr;
    dfs_pkg::ram_rd_t ram_rd;
    dfs_pkg::entry_t  ram_rd_data;
    dfs_pkg::pos_t    pos;

    logic [dfs_pkg::RND_W-1:0] frac;
    logic                      push;
    logic                      slot_free;
    logic                      out_valid_reg;
    logic                      found_reg;
    logic signed [5:0]         code_reg;
    logic [15:0]               energy_reg;
    logic signed [31:0]        pos_x_reg;
    logic signed [31:0]        pos_y_reg;
    logic signed [31:0]        pos_z_reg;
    logic [8:0]                count_reg;
    logic                      ovf_reg;

    assign item.command      = flux_item.command;
    assign item.energy       = flux_item.energy;
    assign item.weights[0]   = flux_item.weight_e_nu;
    assign item.weights[1]   = flux_item.weight_mu_nu;
    assign item.weights[2]   = flux_item.weight_tau_nu;
    assign item.weights[3]   = flux_item.weight_e_antinu;
    assign item.weights[4]   = flux_item.weight_mu_antinu;
    assign item.weights[5]   = flux_item.weight_tau_antinu;
    assign item.random_value = flux_item.random_value;

    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg <= '0;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                dfs_pkg::CFG_CENTRE_X: geom_reg.centre_x <= $signed(cfg_wr.data);
                dfs_pkg::CFG_CENTRE_Y: geom_reg.centre_y <= $signed(cfg_wr.data);
                dfs_pkg::CFG_CENTRE_Z: geom_reg.centre_z <= $signed(cfg_wr.data);
                dfs_pkg::CFG_SPAN_X:   geom_reg.span_x <= cfg_wr.data[dfs_pkg::SPAN_W-1:0];
                dfs_pkg::CFG_SPAN_Y:   geom_reg.span_y <= cfg_wr.data[dfs_pkg::SPAN_W-1:0];
                dfs_pkg::CFG_SPAN_Z:   geom_reg.span_z <= cfg_wr.data[dfs_pkg::SPAN_W-1:0];
                default:               geom_reg <= geom_reg;
            endcase
        end
    end

    dfs_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (flux_item.valid),
        .item        (item),
        .item_ready  (flux_item.ready),
        .slot_free   (slot_free),
        .push        (push),
        .result      (result),
        .frac        (frac),
        .ram_wr      (ram_wr),
        .ram_rd      (ram_rd),
        .ram_rd_data (ram_rd_data)
    );

    dfs_table_ram u_table_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    dfs_position u_position (
        .clk  (clk),
        .geom (geom_reg),
        .frac (frac),
        .pos  (pos)
    );

    assign slot_free = !out_valid_reg || flux_result.ready;

    // Fields that carry no meaning when nothing was found are forced to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (flux_result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            found_reg  <= result.found;
            code_reg   <= result.found ? dfs_pkg::kind_code(result.kind) : '0;
            energy_reg <= result.found ? result.energy : '0;
            pos_x_reg  <= result.found ? pos.x : '0;
            pos_y_reg  <= result.found ? pos.y : '0;
            pos_z_reg  <= result.found ? pos.z : '0;
            count_reg  <= 9'(result.count);
            ovf_reg    <= result.overflow;
        end
    end

    assign flux_result.valid          = out_valid_reg;
    assign flux_result.found          = found_reg;
    assign flux_result.particle_code  = code_reg;
    assign flux_result.sampled_energy = energy_reg;
    assign flux_result.pos_x          = pos_x_reg;
    assign flux_result.pos_y          = pos_y_reg;
    assign flux_result.pos_z          = pos_z_reg;
    assign flux_result.entry_count    = count_reg;
    assign flux_result.overflow       = ovf_reg;

endmodule
